// File: hw/rtl/lsmbd_pkg.sv
// Shared types, constants and helpers for the multi-byte delimiter line framer.
// No dependencies; every other hw/rtl file but lsmbd_fifo refers to it by scoped name.
package lsmbd_pkg;

  // Payload and register widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_LEN_W = 4;
  localparam int ADDR_W    = 5;
  localparam int SEL_W     = 3;

  // Register map, index taken from paddr[4:3]
  localparam logic [1:0] REG_DELIM_BYTES   = 2'd0;
  localparam logic [1:0] REG_DELIM_LEN     = 2'd1;
  localparam logic [1:0] REG_COMMENT_BYTES = 2'd2;
  localparam logic [1:0] REG_COMMENT_LEN   = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0]     DELIM_BYTES_RST   = 64'd10;
  localparam logic [CFG_LEN_W-1:0] DELIM_LEN_RST     = 4'd1;
  localparam logic [CFG_W-1:0]     COMMENT_BYTES_RST = 64'd0;
  localparam logic [CFG_LEN_W-1:0] COMMENT_LEN_RST   = 4'd0;

  // Comment decision for the current line
  typedef enum logic [1:0] {
    PH_UNDECIDED,
    PH_KEEP,
    PH_DROP
  } phase_e;

  // Configuration as seen by the front end
  typedef struct packed {
    logic [CFG_W-1:0]     delim_bytes;
    logic [CFG_LEN_W-1:0] delim_len;
    logic [CFG_W-1:0]     comment_bytes;
    logic [CFG_LEN_W-1:0] comment_len;
  } cfg_t;

  // Byte i of a packed 8-byte register, first byte in bits 7:0
  function automatic logic [BYTE_W-1:0] cfg_byte(input logic [CFG_W-1:0] r,
                                                 input logic [SEL_W-1:0] i);
    cfg_byte = r[i*BYTE_W +: BYTE_W];
  endfunction

endpackage

// File: hw/rtl/lsmbd_in_if.sv
// Input stream channel: valid/ready handshake carrying one stream beat.
// Depends on lsmbd_pkg for field widths.
interface lsmbd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lsmbd_pkg::BYTE_W-1:0] in_byte;

  modport source(output valid, kind, in_byte, input ready);
  modport sink(input valid, kind, in_byte, output ready);
endinterface

// File: hw/rtl/lsmbd_out_if.sv
// Result channel: valid/ready handshake carrying one framed line beat.
// Depends on lsmbd_pkg for field widths.
interface lsmbd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsmbd_pkg::BYTE_W-1:0] out_byte;
  logic                        has_byte;
  logic                        line_end;
  logic [lsmbd_pkg::LEN_W-1:0]  line_length;

  modport source(output valid, out_byte, has_byte, line_end, line_length, input ready);
  modport sink(input valid, out_byte, has_byte, line_end, line_length, output ready);
endinterface

// File: hw/rtl/line_splitter_multi_byte_delim_top.sv
// Top level of the multi-byte delimiter line framer: APB register block, front
// end, record queue and back end. Uses lsmbd_pkg, lsmbd_in_if, lsmbd_out_if.
//
// Usage:
//   in_i carries stream beats (kind 0 = data byte, kind 1 = end of stream); out_o
//   carries one beat per line content byte, or one empty-line marker, with the
//   last beat of a line flagged by line_end and the running line length.
//   Registers (64-bit APB, byte address 8*i): delim_bytes, delim_len,
//   comment_bytes, comment_len. Write them only while the block is idle.
// Throughput: one input beat per cycle. A delimiter or end of stream can release
//   up to HOLD_DEPTH beats at once; the back end drains them one per cycle while
//   out_o accepts, and in_i.ready drops while the QUEUE_DEPTH-entry record queue is full.
// Path: a released byte passes through the queue, the back end's current-record
//   register and the output register on its way to out_o.
// Reset: registers return to delimiter LF, no comment prefix; the current line,
//   queue and output register are cleared. No clearing pass is needed.
// Receiver stall: out_o holds its beat; the back end stops, the queue fills,
//   then in_i.ready goes low until room frees up.
module line_splitter_multi_byte_delim_top #(
  parameter int MAX_DELIM   = 8,
  parameter int MAX_COMMENT = 8,
  parameter int HOLD_DEPTH  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lsmbd_pkg::ADDR_W-1:0]   paddr,
  input  logic [lsmbd_pkg::CFG_W-1:0]    pwdata,
  output logic [lsmbd_pkg::CFG_W-1:0]    prdata,
  output logic                           pready,
  lsmbd_in_if.sink                       in_i,
  lsmbd_out_if.source                    out_o
);

  localparam int REC_W = HOLD_DEPTH * lsmbd_pkg::BYTE_W + $clog2(HOLD_DEPTH + 1) + 1;
  localparam int PAD_W = lsmbd_pkg::CFG_W - lsmbd_pkg::CFG_LEN_W;

  lsmbd_pkg::cfg_t cfg_q;
  logic [1:0]      reg_idx;
  logic            cfg_wr;
  logic            q_push_valid, q_full, q_pop_valid, q_pop_ready;
  logic [REC_W-1:0] q_push_data, q_pop_data;

  // APB register block
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim_bytes   <= lsmbd_pkg::DELIM_BYTES_RST;
      cfg_q.delim_len     <= lsmbd_pkg::DELIM_LEN_RST;
      cfg_q.comment_bytes <= lsmbd_pkg::COMMENT_BYTES_RST;
      cfg_q.comment_len   <= lsmbd_pkg::COMMENT_LEN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        lsmbd_pkg::REG_DELIM_BYTES:   cfg_q.delim_bytes   <= pwdata;
        lsmbd_pkg::REG_DELIM_LEN:     cfg_q.delim_len     <= pwdata[lsmbd_pkg::CFG_LEN_W-1:0];
        lsmbd_pkg::REG_COMMENT_BYTES: cfg_q.comment_bytes <= pwdata;
        lsmbd_pkg::REG_COMMENT_LEN:   cfg_q.comment_len   <= pwdata[lsmbd_pkg::CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      lsmbd_pkg::REG_DELIM_BYTES:   prdata = cfg_q.delim_bytes;
      lsmbd_pkg::REG_DELIM_LEN:     prdata = {{PAD_W{1'b0}}, cfg_q.delim_len};
      lsmbd_pkg::REG_COMMENT_BYTES: prdata = cfg_q.comment_bytes;
      lsmbd_pkg::REG_COMMENT_LEN:   prdata = {{PAD_W{1'b0}}, cfg_q.comment_len};
      default:                      prdata = '0;
    endcase
  end

  lsmbd_front #(
    .MAX_DELIM   (MAX_DELIM),
    .MAX_COMMENT (MAX_COMMENT),
    .HOLD_DEPTH  (HOLD_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .q_full_i     (q_full),
    .push_valid_o (q_push_valid),
    .push_data_o  (q_push_data)
  );

  lsmbd_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_data_i  (q_push_data),
    .full_o       (q_full),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  lsmbd_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_data_i  (q_pop_data),
    .pop_ready_o (q_pop_ready),
    .out_o       (out_o)
  );

  // The front end never pushes a record into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push_valid && q_full))
    else $error("record pushed into full queue");

  // An empty-line marker carries no byte and always closes the line
  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.has_byte) |-> (out_o.line_end && out_o.out_byte == '0))
    else $error("malformed empty-line marker");

  // A beat that carries a byte always reports a nonzero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.has_byte) |-> (out_o.line_length != '0))
    else $error("content beat with zero line length");

endmodule

// File: hw/rtl/lsmbd_front.sv
// Front end: holds back line bytes, matches delimiter and comment prefix, and
// pushes release records {end, count, bytes} into the queue. Uses lsmbd_pkg, lsmbd_in_if.
module lsmbd_front #(
  parameter int MAX_DELIM   = 8,
  parameter int MAX_COMMENT = 8,
  parameter int HOLD_DEPTH  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lsmbd_pkg::cfg_t       cfg_i,
  lsmbd_in_if.sink              in_i,
  input  logic                  q_full_i,
  output logic                  push_valid_o,
  output logic [HOLD_DEPTH*lsmbd_pkg::BYTE_W+$clog2(HOLD_DEPTH+1):0] push_data_o
);

  localparam int BW     = lsmbd_pkg::BYTE_W;
  localparam int CW     = $clog2(HOLD_DEPTH + 1);
  localparam int HW     = HOLD_DEPTH * BW;
  localparam int DL_MAX = (MAX_DELIM < HOLD_DEPTH - 1) ? MAX_DELIM : HOLD_DEPTH - 1;
  localparam int SW     = lsmbd_pkg::SEL_W;

  logic [HW-1:0]     hold_q, hold_d, hold_a, hold_sh;
  logic [CW-1:0]     hcnt_q, hcnt_d, n1, dl, cl, cl_lim, base, drop, avail, rec_cnt;
  logic [CW:0]       cl_dl;
  lsmbd_pkg::phase_e phase_q, phase_d, phase_eff;
  logic              started_q, started_d;
  logic              acc, app, tail_bad, pref_bad, delim_hit, comment_hit, decide, rec_end;

  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && in_i.ready;

  // Effective delimiter and comment lengths
  always_comb begin
    if (cfg_i.delim_len == '0) begin
      dl = CW'(1);
    end else if (int'(cfg_i.delim_len) > DL_MAX) begin
      dl = CW'(DL_MAX);
    end else begin
      dl = CW'(cfg_i.delim_len);
    end
    cl_lim = CW'(HOLD_DEPTH) - dl;
    if (int'(cfg_i.comment_len) > MAX_COMMENT) begin
      cl = CW'(MAX_COMMENT);
    end else begin
      cl = CW'(cfg_i.comment_len);
    end
    if (cl > cl_lim) begin
      cl = cl_lim;
    end
  end

  // Append the incoming byte at the end of the hold window
  always_comb begin
    app    = !in_i.kind && (hcnt_q < CW'(HOLD_DEPTH));
    hold_a = hold_q;
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      if (app && hcnt_q == CW'(k)) begin
        hold_a[k*BW +: BW] = in_i.in_byte;
      end
    end
    n1 = hcnt_q + CW'(app);
  end

  // Delimiter match on the tail of the window
  always_comb begin
    base     = n1 - dl;
    tail_bad = 1'b0;
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      if (CW'(k) >= base && CW'(k) < n1 &&
          hold_a[k*BW +: BW] !=
            lsmbd_pkg::cfg_byte(cfg_i.delim_bytes, SW'(CW'(k) - base))) begin
        tail_bad = 1'b1;
      end
    end
    delim_hit = !in_i.kind && (n1 >= dl) && !tail_bad;
  end

  // Comment prefix match on the head of the window
  always_comb begin
    pref_bad = 1'b0;
    for (int i = 0; i < MAX_COMMENT; i++) begin
      if (CW'(i) < cl &&
          hold_a[i*BW +: BW] != lsmbd_pkg::cfg_byte(cfg_i.comment_bytes, SW'(i))) begin
        pref_bad = 1'b1;
      end
    end
    avail       = delim_hit ? base : n1;
    comment_hit = (cl != '0) && (avail >= cl) && !pref_bad;
  end

  // Comment decision: next state
  always_comb begin
    cl_dl = {1'b0, cl} + {1'b0, dl};
    if (in_i.kind) begin
      decide = started_q && (phase_q == lsmbd_pkg::PH_UNDECIDED);
    end else if (delim_hit) begin
      decide = (phase_q == lsmbd_pkg::PH_UNDECIDED);
    end else begin
      decide = (phase_q == lsmbd_pkg::PH_UNDECIDED) && ({1'b0, n1} >= cl_dl);
    end
    if (decide) begin
      phase_eff = comment_hit ? lsmbd_pkg::PH_DROP : lsmbd_pkg::PH_KEEP;
    end else begin
      phase_eff = phase_q;
    end
    phase_d = (in_i.kind || delim_hit) ? lsmbd_pkg::PH_UNDECIDED : phase_eff;
  end

  // Release records and window update
  always_comb begin
    drop         = base;
    hold_sh      = hold_a >> {drop, 3'b000};
    push_valid_o = 1'b0;
    rec_cnt      = '0;
    rec_end      = 1'b0;
    hold_d       = hold_a;
    hcnt_d       = n1;
    started_d    = started_q;
    if (in_i.kind) begin
      push_valid_o = acc && started_q && (phase_eff == lsmbd_pkg::PH_KEEP);
      rec_cnt      = n1;
      rec_end      = 1'b1;
      hcnt_d       = '0;
      started_d    = 1'b0;
    end else if (delim_hit) begin
      push_valid_o = acc && (phase_eff == lsmbd_pkg::PH_KEEP);
      rec_cnt      = base;
      rec_end      = 1'b1;
      hcnt_d       = '0;
      started_d    = 1'b0;
    end else begin
      started_d = 1'b1;
      if (phase_eff != lsmbd_pkg::PH_UNDECIDED && n1 > dl) begin
        push_valid_o = acc && (phase_eff == lsmbd_pkg::PH_KEEP);
        rec_cnt      = drop;
        hold_d       = hold_sh;
        hcnt_d       = dl;
      end
    end
  end

  assign push_data_o = {rec_end, rec_cnt, hold_a};

  // Line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q    <= '0;
      phase_q   <= lsmbd_pkg::PH_UNDECIDED;
      started_q <= 1'b0;
    end else if (acc) begin
      hcnt_q    <= hcnt_d;
      phase_q   <= phase_d;
      started_q <= started_d;
    end
  end

  // Hold window bytes
  always_ff @(posedge clk_i) begin
    if (acc) begin
      hold_q <= hold_d;
    end
  end

endmodule

// File: hw/rtl/lsmbd_fifo.sv
// Short record queue between front and back ends, register based.
// No package dependencies; depth of 2 or more.
module lsmbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign full_o      = (cnt_q == NW'(DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_valid_o && pop_ready_i;

  // Pointer and fill count
  always_comb begin
    wr_d  = push ? ((wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/lsmbd_back.sv
// Back end: unpacks release records one beat per cycle while the receiver accepts,
// keeps the saturating line length and drives the registered result channel. Uses lsmbd_pkg, lsmbd_out_if.
module lsmbd_back #(
  parameter int HOLD_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pop_valid_i,
  input  logic [HOLD_DEPTH*lsmbd_pkg::BYTE_W+$clog2(HOLD_DEPTH+1):0] pop_data_i,
  output logic pop_ready_o,
  lsmbd_out_if.source out_o
);

  localparam int BW = lsmbd_pkg::BYTE_W;
  localparam int LW = lsmbd_pkg::LEN_W;
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int HW = HOLD_DEPTH * BW;

  logic          cur_valid_q, cur_valid_d;
  logic [HW-1:0] cur_data_q, cur_data_d;
  logic [CW-1:0] cur_left_q, cur_left_d, rec_cnt;
  logic          cur_end_q, cur_end_d, cur_mark_q, cur_mark_d;
  logic          ov_q, ov_d, oh_q, oh_d, oe_q, oe_d;
  logic [BW-1:0] ob_q, ob_d;
  logic [LW-1:0] ol_q, ol_d, line_cnt_q, line_cnt_d, inc;
  logic          emit, last, load;

  // Record unpacking and result generation
  always_comb begin
    emit        = cur_valid_q && (!ov_q || out_o.ready);
    last        = (cur_left_q == CW'(1));
    pop_ready_o = !cur_valid_q || (emit && last);
    load        = pop_valid_i && pop_ready_o;
    rec_cnt     = pop_data_i[HW +: CW];

    cur_valid_d = cur_valid_q;
    cur_data_d  = cur_data_q;
    cur_left_d  = cur_left_q;
    cur_end_d   = cur_end_q;
    cur_mark_d  = cur_mark_q;
    if (emit) begin
      if (last) begin
        cur_valid_d = 1'b0;
      end else begin
        cur_data_d = cur_data_q >> BW;
        cur_left_d = cur_left_q - 1'b1;
      end
    end
    if (load) begin
      cur_valid_d = 1'b1;
      cur_data_d  = pop_data_i[HW-1:0];
      cur_mark_d  = (rec_cnt == '0);
      cur_left_d  = (rec_cnt == '0) ? CW'(1) : rec_cnt;
      cur_end_d   = pop_data_i[HW+CW];
    end

    // Saturating length, cleared after the line's last beat
    inc = (!cur_mark_q && line_cnt_q != '1) ? line_cnt_q + 1'b1 : line_cnt_q;

    ov_d       = ov_q;
    ob_d       = ob_q;
    oh_d       = oh_q;
    oe_d       = oe_q;
    ol_d       = ol_q;
    line_cnt_d = line_cnt_q;
    if (emit) begin
      ov_d       = 1'b1;
      ob_d       = cur_mark_q ? '0 : cur_data_q[BW-1:0];
      oh_d       = !cur_mark_q;
      oe_d       = cur_end_q && last;
      ol_d       = inc;
      line_cnt_d = (cur_end_q && last) ? '0 : inc;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      ov_q        <= 1'b0;
      line_cnt_q  <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      ov_q        <= ov_d;
      line_cnt_q  <= line_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_data_q <= cur_data_d;
    cur_left_q <= cur_left_d;
    cur_end_q  <= cur_end_d;
    cur_mark_q <= cur_mark_d;
    ob_q       <= ob_d;
    oh_q       <= oh_d;
    oe_q       <= oe_d;
    ol_q       <= ol_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_byte    = ob_q;
  assign out_o.has_byte    = oh_q;
  assign out_o.line_end    = oe_q;
  assign out_o.line_length = ol_q;

endmodule
